FILE: src/sacd_pkg.sv
// Package for the set-associative cache directory.
// Holds the command codes and the transaction structures shared by the front,
// the queue and the back end. It depends on nothing.
package sacd_pkg;

  localparam logic [1:0] CMD_ACCESS = 2'd0;
  localparam logic [1:0] CMD_INVAL  = 2'd1;
  localparam logic [1:0] CMD_EVICT  = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] CFG_WAYS   = 2'd0;
  localparam logic [1:0] CFG_OFFSET = 2'd1;
  localparam logic [1:0] CFG_INDEX  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] address;
    logic        is_write;
    logic [19:0] virt_page;
    logic [19:0] phys_frame;
    logic [31:0] tag;
    logic [11:0] set_idx;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [31:0] victim_address;
    logic [31:0] victim_tag;
    logic [7:0]  victim_index;
    logic        victim_dirty;
    logic [19:0] victim_virt_page;
    logic [19:0] victim_frame;
    logic [2:0]  way;
  } rsp_t;

endpackage

FILE: src/sacd_front.sv
// Front end of the cache directory: accepts a transaction and splits the
// address into tag and set index. Depends on sacd_pkg.
module sacd_front #(
  parameter int SET_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_cmd,
  input  logic [31:0]      in_address,
  input  logic             in_is_write,
  input  logic [19:0]      in_virt_page,
  input  logic [19:0]      in_phys_frame,
  input  logic [3:0]       offset_bits,
  input  logic [3:0]       idx_field_bits,
  output logic             req_valid,
  input  logic             req_ready,
  output sacd_pkg::req_t   req
);
  logic          full_r;
  sacd_pkg::req_t req_r;
  logic [31:0]   shifted;
  logic [31:0]   idx_mask;
  logic [31:0]   tag_c;
  logic [4:0]    tsh;

  assign in_ready  = !full_r || req_ready;
  assign req_valid = full_r;
  assign req       = req_r;

  always_comb begin
    shifted  = in_address >> offset_bits;
    idx_mask = (32'd1 << idx_field_bits) - 32'd1;
    tsh      = 5'(offset_bits) + 5'(idx_field_bits);
    tag_c    = (6'(offset_bits) + 6'(idx_field_bits) > 6'd31) ? 32'd0 : (in_address >> tsh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_ready) begin
      full_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      req_r.cmd        <= in_cmd;
      req_r.address    <= in_address;
      req_r.is_write   <= in_is_write;
      req_r.virt_page  <= in_virt_page;
      req_r.phys_frame <= in_phys_frame;
      req_r.tag        <= tag_c;
      req_r.set_idx    <= 12'(SET_BITS'(shifted & idx_mask));
    end
  end
endmodule

FILE: src/sacd_back.sv
// Back end of the cache directory: reads the set, compares the ways in use,
// updates the line memory and builds the result. Depends on sacd_pkg.
module sacd_back #(
  parameter int SETS       = 256,
  parameter int WAYS       = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [3:0]       ways_in_use,
  input  logic             req_valid,
  output logic             req_ready,
  input  sacd_pkg::req_t   req,
  output logic             out_valid,
  input  logic             out_ready,
  output sacd_pkg::rsp_t   rsp
);
  localparam int SB = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] address;
    logic [19:0] virt_page;
    logic [19:0] frame;
  } pay_t;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_WALK, S_OUT} state_t;

  state_t state_r;
  logic [SB-1:0]  set_r;
  logic [SB:0]    clr_r;
  sacd_pkg::req_t req_r;
  sacd_pkg::rsp_t rsp_r;

  logic [WAYS-1:0]            val_mem [SETS];
  logic [WAYS-1:0]            dir_mem [SETS];
  logic [WAYS*COUNT_BITS-1:0] cnt_mem [SETS];
  pay_t [WAYS-1:0]            pay_mem [SETS];

  logic [WAYS-1:0]            val_q, dir_q;
  logic [WAYS*COUNT_BITS-1:0] cnt_q;
  pay_t [WAYS-1:0]            pay_q;

  logic [4:0]  nways;
  logic [WAYS-1:0] act, hitv, frmv;
  logic        any_hit, any_inv;
  logic [WB-1:0] hit_w, inv_w, lfu_w, sel_w;
  logic [COUNT_BITS-1:0] best_c;

  logic [SB-1:0]  rd_set;

  always_comb begin
    nways = (ways_in_use == 4'd0) ? 5'd1 :
            (5'(ways_in_use) > 5'(WAYS)) ? 5'(WAYS) : 5'(ways_in_use);
    any_hit = 1'b0; any_inv = 1'b0;
    hit_w = '0; inv_w = '0; lfu_w = '0;
    best_c = cnt_q[COUNT_BITS-1:0];
    for (int w = 0; w < WAYS; w++) begin
      act[w]  = (5'(w) < nways);
      hitv[w] = act[w] && val_q[w] && (pay_q[w].tag == req_r.tag);
      frmv[w] = act[w] && val_q[w] && (pay_q[w].frame == req_r.phys_frame);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hitv[w]) begin any_hit = 1'b1; hit_w = WB'(w); end
      if (act[w] && !val_q[w]) begin any_inv = 1'b1; inv_w = WB'(w); end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (act[w] && cnt_q[w*COUNT_BITS +: COUNT_BITS] < best_c) begin
        best_c = cnt_q[w*COUNT_BITS +: COUNT_BITS];
        lfu_w  = WB'(w);
      end
    end
    sel_w = any_inv ? inv_w : lfu_w;
    rd_set = (state_r == S_IDLE) ? SB'(req.set_idx) :
             (state_r == S_WALK && req_r.cmd != sacd_pkg::CMD_INVAL) ? set_r + SB'(1) :
             set_r;
  end

  assign req_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign rsp       = rsp_r;

  always_ff @(posedge clk) begin
    val_q <= val_mem[rd_set];
    dir_q <= dir_mem[rd_set];
    cnt_q <= cnt_mem[rd_set];
    pay_q <= pay_mem[rd_set];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          val_mem[clr_r[SB-1:0]] <= '0;
          dir_mem[clr_r[SB-1:0]] <= '0;
          cnt_mem[clr_r[SB-1:0]] <= '0;
          clr_r <= clr_r + 1'b1;
          if (clr_r == (SB+1)'(SETS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            req_r <= req;
            set_r <= (req.cmd == sacd_pkg::CMD_INVAL) ? '0 : SB'(req.set_idx);
            rsp_r <= '0;
            state_r <= (req.cmd == sacd_pkg::CMD_INVAL) ? S_WALK : S_READ;
          end
        end
        S_READ: state_r <= S_EXEC;
        S_EXEC: begin
          state_r <= S_OUT;
          unique case (req_r.cmd)
            sacd_pkg::CMD_ACCESS: begin
              if (any_hit) begin
                rsp_r.hit <= 1'b1;
                rsp_r.way <= 3'(hit_w);
                if (req_r.is_write) dir_mem[set_r][hit_w] <= 1'b1;
                if (cnt_q[hit_w*COUNT_BITS +: COUNT_BITS] != CMAX)
                  cnt_mem[set_r][hit_w*COUNT_BITS +: COUNT_BITS] <=
                    cnt_q[hit_w*COUNT_BITS +: COUNT_BITS] + 1'b1;
              end else begin
                rsp_r.way <= 3'(sel_w);
                if (!any_inv) begin
                  rsp_r.evicted          <= 1'b1;
                  rsp_r.victim_address   <= pay_q[sel_w].address;
                  rsp_r.victim_tag       <= pay_q[sel_w].tag;
                  rsp_r.victim_index     <= 8'(set_r);
                  rsp_r.victim_dirty     <= dir_q[sel_w];
                  rsp_r.victim_virt_page <= pay_q[sel_w].virt_page;
                  rsp_r.victim_frame     <= pay_q[sel_w].frame;
                end
                val_mem[set_r][sel_w] <= 1'b1;
                dir_mem[set_r][sel_w] <= req_r.is_write;
                cnt_mem[set_r][sel_w*COUNT_BITS +: COUNT_BITS] <= COUNT_BITS'(1);
                pay_mem[set_r][sel_w] <= '{req_r.tag, req_r.address,
                                           req_r.virt_page, req_r.phys_frame};
              end
            end
            sacd_pkg::CMD_EVICT: begin
              if (any_hit) begin
                rsp_r.hit              <= 1'b1;
                rsp_r.evicted          <= 1'b1;
                rsp_r.way              <= 3'(hit_w);
                rsp_r.victim_address   <= pay_q[hit_w].address;
                rsp_r.victim_tag       <= pay_q[hit_w].tag;
                rsp_r.victim_index     <= 8'(set_r);
                rsp_r.victim_dirty     <= dir_q[hit_w];
                rsp_r.victim_virt_page <= pay_q[hit_w].virt_page;
                rsp_r.victim_frame     <= pay_q[hit_w].frame;
                val_mem[set_r][hit_w] <= 1'b0;
                dir_mem[set_r][hit_w] <= 1'b0;
                cnt_mem[set_r][hit_w*COUNT_BITS +: COUNT_BITS] <= '0;
              end
            end
            default: ;
          endcase
        end
        S_WALK: begin
          if (req_r.cmd == sacd_pkg::CMD_INVAL) begin
            // On entry this state only loads set zero; req_r.cmd is then cleared.
            req_r.cmd <= sacd_pkg::CMD_NOP;
          end else begin
            for (int w = 0; w < WAYS; w++) begin
              if (frmv[w]) begin
                val_mem[set_r][w] <= 1'b0;
                dir_mem[set_r][w] <= 1'b0;
                cnt_mem[set_r][w*COUNT_BITS +: COUNT_BITS] <= '0;
              end
            end
            if (|frmv) rsp_r.evicted <= 1'b1;
            set_r <= set_r + SB'(1);
            if (set_r == SB'(SETS - 1)) state_r <= S_OUT;
          end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: src/set_assoc_cache_directory.sv
// Set-associative cache directory: front end with a one-entry queue, back end.
// Access and evict: read, execute, output; invalidate by frame walks all sets.
// One transaction is in the back end at a time; the front holds the next.
// After reset the back end clears every set before it takes a transaction.
// Depends on sacd_pkg, sacd_front and sacd_back.
module set_assoc_cache_directory #(
  parameter int SETS       = 256,
  parameter int WAYS       = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_address,
  input  logic        in_is_write,
  input  logic [19:0] in_virt_page,
  input  logic [19:0] in_phys_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic        out_evicted,
  output logic [31:0] out_victim_address,
  output logic [31:0] out_victim_tag,
  output logic [7:0]  out_victim_index,
  output logic        out_victim_dirty,
  output logic [19:0] out_victim_virt_page,
  output logic [19:0] out_victim_frame,
  output logic [2:0]  out_way
);
  localparam int SB = (SETS > 1) ? $clog2(SETS) : 1;
  logic [3:0] ways_r, off_r, idx_r;
  logic req_valid, req_ready;
  sacd_pkg::req_t req;
  sacd_pkg::rsp_t rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r <= 4'd1; off_r <= 4'd6; idx_r <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sacd_pkg::CFG_WAYS:   ways_r <= cfg_data;
        sacd_pkg::CFG_OFFSET: off_r  <= cfg_data;
        sacd_pkg::CFG_INDEX:  idx_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  sacd_front #(.SET_BITS(SB)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_address, .in_is_write,
    .in_virt_page, .in_phys_frame, .offset_bits(off_r), .idx_field_bits(idx_r),
    .req_valid, .req_ready, .req
  );

  sacd_back #(.SETS(SETS), .WAYS(WAYS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .ways_in_use(ways_r), .req_valid, .req_ready, .req,
    .out_valid, .out_ready, .rsp
  );

  assign out_hit              = rsp.hit;
  assign out_evicted          = rsp.evicted;
  assign out_victim_address   = rsp.victim_address;
  assign out_victim_tag       = rsp.victim_tag;
  assign out_victim_index     = rsp.victim_index;
  assign out_victim_dirty     = rsp.victim_dirty;
  assign out_victim_virt_page = rsp.victim_virt_page;
  assign out_victim_frame     = rsp.victim_frame;
  assign out_way              = rsp.way;
endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the set-associative cache directory.
// Holds a directory predictor, a directed table and random traffic with idling.
// Depends on sacd_pkg and set_assoc_cache_directory.
module tb_top;

  localparam int SETS = 256;
  localparam int WAYS = 8;
  localparam int COUNT_MAX = 65535;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]      cmd;
    logic [31:0]     address;
    logic            is_write;
    logic [19:0]     virt_page;
    logic [19:0]     phys_frame;
    logic            has_fixed;
    sacd_pkg::rsp_t  fixed;
  } stim_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] in_cmd;
  logic [31:0] in_address;
  logic in_is_write;
  logic [19:0] in_virt_page, in_phys_frame;
  logic out_valid, out_ready;
  logic out_hit, out_evicted, out_victim_dirty;
  logic [31:0] out_victim_address, out_victim_tag;
  logic [7:0] out_victim_index;
  logic [19:0] out_victim_virt_page, out_victim_frame;
  logic [2:0] out_way;

  set_assoc_cache_directory uut (.*);

  bit          dir_valid [SETS*WAYS];
  bit          dir_dirty [SETS*WAYS];
  logic [31:0] dir_tag   [SETS*WAYS];
  logic [31:0] dir_addr  [SETS*WAYS];
  int          dir_count [SETS*WAYS];
  logic [19:0] dir_vpage [SETS*WAYS];
  logic [19:0] dir_frame [SETS*WAYS];
  logic [3:0]  ways_reg, offset_reg, index_reg;

  sacd_pkg::rsp_t expected_rsp[$];
  int   fail_count;
  int   idle_cycles;
  bit   hold_off;

  function automatic sacd_pkg::rsp_t victim_of(int set, int w);
    sacd_pkg::rsp_t r;
    int k;
    k = set * WAYS + w;
    r = '0;
    r.evicted = 1;
    r.victim_address = dir_addr[k];
    r.victim_tag = dir_tag[k];
    r.victim_index = set[7:0];
    r.victim_dirty = dir_dirty[k];
    r.victim_virt_page = dir_vpage[k];
    r.victim_frame = dir_frame[k];
    r.way = w[2:0];
    return r;
  endfunction

  function automatic sacd_pkg::rsp_t predict_directory(stim_t s);
    sacd_pkg::rsp_t r;
    int nways, set, base, w, best, k;
    logic [31:0] tag;
    logic [63:0] wide;
    r = '0;
    nways = (ways_reg == 0) ? 1 : (ways_reg > WAYS) ? WAYS : ways_reg;
    wide = {32'd0, s.address} >> offset_reg;
    set = int'(wide & ((64'd1 << index_reg) - 1)) % SETS;
    tag = 32'(({32'd0, s.address}) >> (int'(offset_reg) + int'(index_reg)));
    base = set * WAYS;
    case (s.cmd)
      sacd_pkg::CMD_ACCESS: begin
        for (w = 0; w < nways; w++) begin
          k = base + w;
          if (dir_valid[k] && dir_tag[k] == tag) begin
            if (dir_count[k] < COUNT_MAX) dir_count[k]++;
            if (s.is_write) dir_dirty[k] = 1;
            r.hit = 1;
            r.way = w[2:0];
            return r;
          end
        end
        for (w = 0; w < nways; w++) if (!dir_valid[base + w]) break;
        if (w == nways) begin
          best = 0;
          for (int j = 1; j < nways; j++)
            if (dir_count[base + j] < dir_count[base + best]) best = j;
          w = best;
          r = victim_of(set, w);
        end
        k = base + w;
        dir_valid[k] = 1;
        dir_dirty[k] = s.is_write;
        dir_tag[k] = tag;
        dir_addr[k] = s.address;
        dir_count[k] = 1;
        dir_vpage[k] = s.virt_page;
        dir_frame[k] = s.phys_frame;
        r.way = w[2:0];
      end
      sacd_pkg::CMD_INVAL: begin
        for (int st = 0; st < SETS; st++)
          for (w = 0; w < nways; w++) begin
            k = st * WAYS + w;
            if (dir_valid[k] && dir_frame[k] == s.phys_frame) begin
              dir_valid[k] = 0;
              dir_dirty[k] = 0;
              dir_count[k] = 0;
              r.evicted = 1;
            end
          end
      end
      sacd_pkg::CMD_EVICT: begin
        for (w = 0; w < nways; w++) begin
          k = base + w;
          if (dir_valid[k] && dir_tag[k] == tag) begin
            r = victim_of(set, w);
            r.hit = 1;
            dir_valid[k] = 0;
            dir_dirty[k] = 0;
            dir_count[k] = 0;
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  task automatic write_register(logic [1:0] idx, logic [3:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      sacd_pkg::CFG_WAYS:   ways_reg = val;
      sacd_pkg::CFG_OFFSET: offset_reg = val;
      default:              index_reg = val;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_directory();
    in_valid <= 0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (SETS + 20) @(posedge clk);
  endtask

  int gap_left, burst_left;

  task automatic send_item(stim_t s);
    sacd_pkg::rsp_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap_left > 0) begin
      in_valid <= 0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_valid <= 1;
    in_cmd <= s.cmd;
    in_address <= s.address;
    in_is_write <= s.is_write;
    in_virt_page <= s.virt_page;
    in_phys_frame <= s.phys_frame;
    do @(posedge clk); while (!in_ready);
    r = predict_directory(s);
    if (s.has_fixed && r != s.fixed) begin
      $display("%0t directed row disagrees with predictor: table %h predictor %h",
               $time, s.fixed, r);
      fail_count++;
    end
    expected_rsp.push_back(r);
  endtask

  function automatic stim_t random_item(bit well_formed);
    stim_t s;
    s.has_fixed = 0;
    s.fixed = '0;
    s.address = $urandom();
    if (well_formed) begin
      // Keep tags and sets in a narrow range so that lines are reused.
      s.address[31:16] = {$urandom_range(0, 1) ? 16'hffff : 16'h0000};
      s.address[15:12] = 4'($urandom_range(0, 3));
      s.address[11:8]  = $urandom_range(0, 1) ? 4'hf : 4'h0;
    end
    case ($urandom_range(0, 19))
      0: s.cmd = sacd_pkg::CMD_INVAL;
      1, 2, 3: s.cmd = sacd_pkg::CMD_EVICT;
      4: s.cmd = sacd_pkg::CMD_NOP;
      default: s.cmd = sacd_pkg::CMD_ACCESS;
    endcase
    s.is_write = 1'($urandom_range(0, 1));
    s.virt_page = 20'($urandom());
    s.phys_frame = $urandom_range(0, 1) ? 20'($urandom_range(0, 7)) : 20'($urandom());
    if ($urandom_range(0, 15) == 0) s.phys_frame = 20'hfffff;
    return s;
  endfunction

  stim_t directed_table[$];

  function automatic stim_t row(logic [1:0] c, logic [31:0] a, logic wr,
                                logic [19:0] vp, logic [19:0] pf);
    stim_t s;
    s.cmd = c; s.address = a; s.is_write = wr; s.virt_page = vp; s.phys_frame = pf;
    s.has_fixed = 0; s.fixed = '0;
    return s;
  endfunction

  function automatic stim_t fixed_row(stim_t s, sacd_pkg::rsp_t r);
    s.has_fixed = 1;
    s.fixed = r;
    return s;
  endfunction

  initial begin
    sacd_pkg::rsp_t zero_rsp, hit_rsp;
    stim_t s;
    zero_rsp = '0;
    hit_rsp = '0;
    hit_rsp.hit = 1;
    rst_n = 0; cfg_we = 0; cfg_index = sacd_pkg::CFG_WAYS; cfg_data = 0;
    in_valid = 0; in_cmd = sacd_pkg::CMD_ACCESS; in_address = 0; in_is_write = 0;
    in_virt_page = 0; in_phys_frame = 0;
    fail_count = 0; burst_left = 0; gap_left = 0;
    ways_reg = 1; offset_reg = 6; index_reg = 8;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset defaults: direct mapped, so a second tag in one set displaces the first.
    directed_table.push_back(fixed_row(row(sacd_pkg::CMD_EVICT, 32'h0, 1'b0, 20'h0, 20'h0),
                                       zero_rsp));
    directed_table.push_back(fixed_row(row(sacd_pkg::CMD_NOP, 32'hffffffff, 1'b1, 20'hfffff,
                                           20'hfffff), zero_rsp));
    directed_table.push_back(fixed_row(row(sacd_pkg::CMD_ACCESS, 32'h0, 1'b0, 20'h0, 20'h1),
                                       zero_rsp));
    directed_table.push_back(fixed_row(row(sacd_pkg::CMD_ACCESS, 32'h3f, 1'b1, 20'h2, 20'h2),
                                       hit_rsp));
    directed_table.push_back(fixed_row(row(sacd_pkg::CMD_ACCESS, 32'h3f, 1'b0, 20'h2, 20'h2),
                                       hit_rsp));
    directed_table.push_back(row(sacd_pkg::CMD_ACCESS, 32'hffffffc0, 1'b1, 20'hfffff,
                                 20'hfffff));
    directed_table.push_back(row(sacd_pkg::CMD_ACCESS, 32'hffffffff, 1'b0, 20'h1, 20'h1));
    directed_table.push_back(row(sacd_pkg::CMD_ACCESS, 32'h00004000, 1'b0, 20'h5, 20'h1));
    directed_table.push_back(row(sacd_pkg::CMD_EVICT, 32'hffffffff, 1'b0, 20'h0, 20'h0));
    directed_table.push_back(row(sacd_pkg::CMD_INVAL, 32'h0, 1'b0, 20'h0, 20'h1));
    directed_table.push_back(fixed_row(row(sacd_pkg::CMD_INVAL, 32'h0, 1'b0, 20'h0, 20'h1),
                                       zero_rsp));
    directed_table.push_back(row(sacd_pkg::CMD_ACCESS, 32'h00000040, 1'b0, 20'h7, 20'h7));
    directed_table.push_back(row(sacd_pkg::CMD_ACCESS, 32'h00000040, 1'b1, 20'h7, 20'h7));
    directed_table.push_back(row(sacd_pkg::CMD_EVICT, 32'h00000040, 1'b0, 20'h0, 20'h0));
    foreach (directed_table[i]) send_item(directed_table[i]);
    drain_directory();

    // Full associativity with a one-bit index: fill, hit, least-used replacement, invalidate.
    write_register(sacd_pkg::CFG_WAYS, 4'd8);
    write_register(sacd_pkg::CFG_INDEX, 4'd1);
    write_register(sacd_pkg::CFG_OFFSET, 4'd0);
    for (int t = 0; t < 10; t++) begin
      s = row(sacd_pkg::CMD_ACCESS, 32'(t << 1), t[0], 20'(t), 20'(t + 100));
      send_item(s);
      if (t < 3) send_item(s);
    end
    send_item(row(sacd_pkg::CMD_INVAL, 32'd0, 1'b0, 20'd0, 20'd105));
    drain_directory();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_register(sacd_pkg::CFG_WAYS, 4'd0);
                 write_register(sacd_pkg::CFG_OFFSET, 4'd12);
                 write_register(sacd_pkg::CFG_INDEX, 4'd0); end
        1: begin write_register(sacd_pkg::CFG_WAYS, 4'd15);
                 write_register(sacd_pkg::CFG_OFFSET, 4'd0);
                 write_register(sacd_pkg::CFG_INDEX, 4'd8); end
        2: begin write_register(sacd_pkg::CFG_WAYS, 4'd4);
                 write_register(sacd_pkg::CFG_OFFSET, 4'd6);
                 write_register(sacd_pkg::CFG_INDEX, 4'd4); end
        3: begin write_register(sacd_pkg::CFG_WAYS, 4'd2);
                 write_register(sacd_pkg::CFG_OFFSET, 4'd12);
                 write_register(sacd_pkg::CFG_INDEX, 4'd8); end
        default: begin write_register(sacd_pkg::CFG_WAYS, 4'd8);
                       write_register(sacd_pkg::CFG_OFFSET, 4'd8);
                       write_register(sacd_pkg::CFG_INDEX, 4'd2); end
      endcase
      if (phase == 2) hold_off = 1;
      for (int n = 0; n < 160; n++) send_item(random_item($urandom_range(0, 9) != 0));
      drain_directory();
    end

    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (SETS + 20) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  int stall_left, long_stall;

  initial begin
    out_ready = 0;
    stall_left = 0;
    long_stall = 0;
    hold_off = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 0;
        long_stall = 300;
      end
      if (long_stall > 0) begin
        long_stall--;
        out_ready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8);
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    sacd_pkg::rsp_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_hit, out_evicted, out_victim_address, out_victim_tag, out_victim_index,
              out_victim_dirty, out_victim_virt_page, out_victim_frame, out_way};
      if (expected_rsp.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        fail_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (got.hit != want.hit)
          $display("%0t hit: expected %h actual %h", $time, want.hit, got.hit);
        if (got.evicted != want.evicted)
          $display("%0t evicted: expected %h actual %h", $time, want.evicted, got.evicted);
        if (got.victim_address != want.victim_address)
          $display("%0t victim_address: expected %h actual %h", $time,
                   want.victim_address, got.victim_address);
        if (got.victim_tag != want.victim_tag)
          $display("%0t victim_tag: expected %h actual %h", $time,
                   want.victim_tag, got.victim_tag);
        if (got.victim_index != want.victim_index)
          $display("%0t victim_index: expected %h actual %h", $time,
                   want.victim_index, got.victim_index);
        if (got.victim_dirty != want.victim_dirty)
          $display("%0t victim_dirty: expected %h actual %h", $time,
                   want.victim_dirty, got.victim_dirty);
        if (got.victim_virt_page != want.victim_virt_page)
          $display("%0t victim_virt_page: expected %h actual %h", $time,
                   want.victim_virt_page, got.victim_virt_page);
        if (got.victim_frame != want.victim_frame)
          $display("%0t victim_frame: expected %h actual %h", $time,
                   want.victim_frame, got.victim_frame);
        if (got.way != want.way)
          $display("%0t way: expected %h actual %h", $time, want.way, got.way);
        if (got !== want) fail_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  final if (expected_rsp.size() != 0) $display("%0t results still outstanding", $time);

endmodule
